// File: sv/ptc_pkg.sv
// ============================================================================
// ptc_pkg
// Shared types and constants for the pressure and temperature compensation
// block: calibration word bundle, register map, pipeline depth and the
// fixed temperature break points.
// ============================================================================
`default_nettype none

package ptc_pkg;

    // Number of register stages in the compensation datapath.
    localparam int NSTG = 9;

    // Configuration port geometry.
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Register map indexes (byte address is four times the index).
    localparam logic [2:0] REG_PRESSURE_SENSITIVITY  = 3'd0;
    localparam logic [2:0] REG_PRESSURE_OFFSET       = 3'd1;
    localparam logic [2:0] REG_SENSITIVITY_TEMP_COEF = 3'd2;
    localparam logic [2:0] REG_OFFSET_TEMP_COEF      = 3'd3;
    localparam logic [2:0] REG_REFERENCE_TEMPERATURE = 3'd4;
    localparam logic [2:0] REG_TEMPERATURE_SLOPE     = 3'd5;

    // Field widths.
    localparam int RAW_W   = 24;
    localparam int TEMP_W  = 19;
    localparam int PRESS_W = 32;

    // Temperature break points in hundredths of a degree, and the same
    // points expressed relative to the 20.00 C reference.
    localparam logic signed [19:0] TEMP_REF_CENTI = 20'sd2000;
    localparam logic signed [19:0] COLD_FROM_REF  = 20'sd3500;
    localparam logic signed [19:0] HOT_FROM_REF   = 20'sd2500;

    // Output saturation limits.
    localparam logic signed [20:0] TEMP_OUT_MAX  = 21'sd262143;
    localparam logic signed [20:0] TEMP_OUT_MIN  = -21'sd262144;
    localparam logic signed [32:0] PRESS_OUT_MAX = 33'sd2147483647;
    localparam logic signed [32:0] PRESS_OUT_MIN = -33'sd2147483648;

    // The six calibration words.
    typedef struct packed {
        logic [15:0] pressure_sensitivity;
        logic [15:0] pressure_offset;
        logic [15:0] sensitivity_temp_coef;
        logic [15:0] offset_temp_coef;
        logic [15:0] reference_temperature;
        logic [15:0] temperature_slope;
    } t_cal;

endpackage

`default_nettype wire

// File: sv/pressure_temp_compensation.sv
// ============================================================================
// pressure_temp_compensation
// Second-order temperature compensation of raw 24-bit pressure and
// temperature readings, with six calibration words on a register port.
// ============================================================================
//
//  Channel   Direction  Signals                          Beat contents
//  --------  ---------  -------------------------------  -------------------------
//  s (in)    input      i_s_tvalid o_s_tready i_s_tdata  raw pressure, raw temp
//  m (out)   output     o_m_tvalid i_m_tready o_m_tdata  temperature, pressure
//  config    input      psel penable pwrite paddr        six calibration words
//                       pwdata prdata pready
//
//  One beat is accepted per cycle while a stage is free; each result passes
//  through the nine register stages of the datapath (the 40 by 24 bit product
//  takes two of them).
//  Reset clears the stage valid bits and the calibration words.
//  A stall at the output fills empty stages first, so input beats are still
//  taken while a result waits, until every stage holds a beat.
//
`default_nettype none

module pressure_temp_compensation
    import ptc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Input stream.
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [47:0]       i_s_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
    // Output stream.
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [55:0]            o_m_tdata,   // [18:0] temperature_centi,
                                                // [50:19] pressure_centi_mbar, [55:51] zero
    // Configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    // ------------------------------------------------------------------
    // Calibration registers.
    // ------------------------------------------------------------------
    t_cal        r_cal;
    logic [2:0]  w_idx;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[APB_AW-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PRESSURE_SENSITIVITY:  r_cal.pressure_sensitivity  <= pwdata[15:0];
                REG_PRESSURE_OFFSET:       r_cal.pressure_offset       <= pwdata[15:0];
                REG_SENSITIVITY_TEMP_COEF: r_cal.sensitivity_temp_coef <= pwdata[15:0];
                REG_OFFSET_TEMP_COEF:      r_cal.offset_temp_coef      <= pwdata[15:0];
                REG_REFERENCE_TEMPERATURE: r_cal.reference_temperature <= pwdata[15:0];
                REG_TEMPERATURE_SLOPE:     r_cal.temperature_slope     <= pwdata[15:0];
                default: begin
                    r_cal <= r_cal;
                end
            endcase
        end
    end

    // Read-back of the calibration words; unused addresses read as zero.
    always_comb begin
        unique case (w_idx)
            REG_PRESSURE_SENSITIVITY:  prdata = {16'd0, r_cal.pressure_sensitivity};
            REG_PRESSURE_OFFSET:       prdata = {16'd0, r_cal.pressure_offset};
            REG_SENSITIVITY_TEMP_COEF: prdata = {16'd0, r_cal.sensitivity_temp_coef};
            REG_OFFSET_TEMP_COEF:      prdata = {16'd0, r_cal.offset_temp_coef};
            REG_REFERENCE_TEMPERATURE: prdata = {16'd0, r_cal.reference_temperature};
            REG_TEMPERATURE_SLOPE:     prdata = {16'd0, r_cal.temperature_slope};
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Compensation datapath.
    // ------------------------------------------------------------------
    logic signed [TEMP_W-1:0]  w_temp;
    logic signed [PRESS_W-1:0] w_press;

    ptc_pipe u_pipe (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cal                 (r_cal),
        .i_in_valid            (i_s_tvalid),
        .o_in_ready            (o_s_tready),
        .i_raw_pressure        (i_s_tdata[23:0]),
        .i_raw_temperature     (i_s_tdata[47:24]),
        .o_out_valid           (o_m_tvalid),
        .i_out_ready           (i_m_tready),
        .o_temperature_centi   (w_temp),
        .o_pressure_centi_mbar (w_press)
    );

    // Result beat packing.
    assign o_m_tdata = {5'd0, w_press, w_temp};

endmodule

`default_nettype wire

// File: sv/ptc_pipe.sv
// ============================================================================
// ptc_pipe
// Nine-stage compensation datapath with per-stage valid bits. Each stage
// loads when it is empty or when the stage after it moves, so bubbles
// close up and the input keeps flowing while a result waits at the output.
// ============================================================================
`default_nettype none

module ptc_pipe
    import ptc_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_cal                        i_cal,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [RAW_W-1:0]            i_raw_pressure,
    input  wire logic [RAW_W-1:0]            i_raw_temperature,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic signed [TEMP_W-1:0]         o_temperature_centi,
    output logic signed [PRESS_W-1:0]        o_pressure_centi_mbar
);

    // ------------------------------------------------------------------
    // Stage flow control.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;
    logic [NSTG-1:0] w_vld_in;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign w_vld_in = {r_vld[NSTG-2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= w_vld_in[k];
                end
            end
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NSTG-1];

    // ------------------------------------------------------------------
    // Stage 0: temperature difference against the reference reading.
    // ------------------------------------------------------------------
    logic        [RAW_W-1:0] r0_d1;
    logic signed [24:0]      r0_dt;
    logic signed [24:0]      n0_dt;

    assign n0_dt = $signed({1'b0, i_raw_temperature})
                 - $signed({1'b0, i_cal.reference_temperature, 8'd0});

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_d1 <= i_raw_pressure;
            r0_dt <= n0_dt;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the four products of the temperature difference.
    // ------------------------------------------------------------------
    logic        [RAW_W-1:0] r1_d1;
    logic signed [41:0]      r1_p6;
    logic signed [41:0]      r1_p4;
    logic signed [41:0]      r1_p3;
    logic signed [49:0]      r1_pdd;
    logic signed [41:0]      n1_p6;
    logic signed [41:0]      n1_p4;
    logic signed [41:0]      n1_p3;
    logic signed [49:0]      n1_pdd;

    assign n1_p6  = r0_dt * $signed({1'b0, i_cal.temperature_slope});
    assign n1_p4  = r0_dt * $signed({1'b0, i_cal.offset_temp_coef});
    assign n1_p3  = r0_dt * $signed({1'b0, i_cal.sensitivity_temp_coef});
    assign n1_pdd = r0_dt * r0_dt;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_d1  <= r0_d1;
            r1_p6  <= n1_p6;
            r1_p4  <= n1_p4;
            r1_p3  <= n1_p3;
            r1_pdd <= n1_pdd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: first-order temperature, linear offset and sensitivity,
    // distances to the break points and the range flags.
    // ------------------------------------------------------------------
    logic signed [19:0] s2_tdiff;
    logic signed [19:0] n2_temp;
    logic signed [19:0] n2_dcold;
    logic signed [19:0] n2_dhot;
    logic        [17:0] n2_t2;
    logic signed [37:0] n2_off_lin;
    logic signed [37:0] n2_sens_lin;
    logic               n2_hot;

    logic        [RAW_W-1:0] r2_d1;
    logic signed [19:0]      r2_temp;
    logic signed [19:0]      r2_dref;
    logic signed [19:0]      r2_dcold;
    logic signed [19:0]      r2_dhot;
    logic        [17:0]      r2_t2;
    logic signed [37:0]      r2_off_lin;
    logic signed [37:0]      r2_sens_lin;
    logic                    r2_cold;
    logic                    r2_extra;
    logic                    r2_hot;

    // Floor shift by 23 is the upper part of the product.
    assign s2_tdiff    = {r1_p6[41], r1_p6[41:23]};
    assign n2_temp     = s2_tdiff + TEMP_REF_CENTI;
    assign n2_dcold    = s2_tdiff + COLD_FROM_REF;
    assign n2_dhot     = s2_tdiff - HOT_FROM_REF;
    // The squared-difference temperature term applies only below 20.00 C.
    assign n2_t2       = s2_tdiff[19] ? r1_pdd[48:31] : 18'd0;
    assign n2_off_lin  = $signed({6'd0, i_cal.pressure_offset, 16'd0})
                       + $signed({{3{r1_p4[41]}}, r1_p4[41:7]});
    assign n2_sens_lin = $signed({7'd0, i_cal.pressure_sensitivity, 15'd0})
                       + $signed({{4{r1_p3[41]}}, r1_p3[41:8]});
    assign n2_hot      = (n2_dhot > 20'sd0);

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_d1       <= r1_d1;
            r2_temp     <= n2_temp;
            r2_dref     <= s2_tdiff;
            r2_dcold    <= n2_dcold;
            r2_dhot     <= n2_dhot;
            r2_t2       <= n2_t2;
            r2_off_lin  <= n2_off_lin;
            r2_sens_lin <= n2_sens_lin;
            r2_cold     <= s2_tdiff[19];
            r2_extra    <= n2_dcold[19];
            r2_hot      <= n2_hot;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squares for the second-order terms, final temperature.
    // ------------------------------------------------------------------
    logic signed [39:0]       n3_sq_ref;
    logic signed [39:0]       n3_sq_cold;
    logic signed [39:0]       n3_sq_hot;
    logic signed [20:0]       s3_temp_full;
    logic signed [TEMP_W-1:0] n3_temp_sat;

    logic        [RAW_W-1:0]  r3_d1;
    logic signed [39:0]       r3_sq_ref;
    logic signed [39:0]       r3_sq_cold;
    logic signed [39:0]       r3_sq_hot;
    logic signed [37:0]       r3_off_lin;
    logic signed [37:0]       r3_sens_lin;
    logic                     r3_cold;
    logic                     r3_extra;
    logic                     r3_hot;
    logic signed [TEMP_W-1:0] r3_temp;

    assign n3_sq_ref    = r2_dref * r2_dref;
    assign n3_sq_cold   = r2_dcold * r2_dcold;
    assign n3_sq_hot    = r2_dhot * r2_dhot;
    assign s3_temp_full = {r2_temp[19], r2_temp} - $signed({3'd0, r2_t2});

    always_comb begin
        priority if (s3_temp_full > TEMP_OUT_MAX) begin
            n3_temp_sat = TEMP_OUT_MAX[TEMP_W-1:0];
        end else if (s3_temp_full < TEMP_OUT_MIN) begin
            n3_temp_sat = TEMP_OUT_MIN[TEMP_W-1:0];
        end else begin
            n3_temp_sat = s3_temp_full[TEMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_d1       <= r2_d1;
            r3_sq_ref   <= n3_sq_ref;
            r3_sq_cold  <= n3_sq_cold;
            r3_sq_hot   <= n3_sq_hot;
            r3_off_lin  <= r2_off_lin;
            r3_sens_lin <= r2_sens_lin;
            r3_cold     <= r2_cold;
            r3_extra    <= r2_extra;
            r3_hot      <= r2_hot;
            r3_temp     <= n3_temp_sat;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: second-order offset and sensitivity corrections.
    // ------------------------------------------------------------------
    logic signed [39:0] s4_seven;
    logic signed [39:0] n4_off2;
    logic signed [39:0] n4_sens2;

    logic        [RAW_W-1:0]  r4_d1;
    logic signed [39:0]       r4_off2;
    logic signed [39:0]       r4_sens2;
    logic signed [37:0]       r4_off_lin;
    logic signed [37:0]       r4_sens_lin;
    logic signed [TEMP_W-1:0] r4_temp;

    assign s4_seven = (r3_sq_ref <<< 3) - r3_sq_ref;

    always_comb begin
        n4_off2  = '0;
        n4_sens2 = '0;
        priority if (r3_cold) begin
            n4_off2 = (r3_sq_ref <<< 1) + r3_sq_ref;
            if (r3_extra) begin
                n4_sens2 = (s4_seven >>> 3) + (r3_sq_cold <<< 1);
            end else begin
                n4_sens2 = s4_seven >>> 3;
            end
        end else if (r3_hot) begin
            n4_sens2 = -(r3_sq_hot >>> 3);
        end else begin
            n4_sens2 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_d1       <= r3_d1;
            r4_off2     <= n4_off2;
            r4_sens2    <= n4_sens2;
            r4_off_lin  <= r3_off_lin;
            r4_sens_lin <= r3_sens_lin;
            r4_temp     <= r3_temp;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: final offset and sensitivity.
    // ------------------------------------------------------------------
    logic signed [39:0] n5_off;
    logic signed [39:0] n5_sens;

    logic        [RAW_W-1:0]  r5_d1;
    logic signed [39:0]       r5_off;
    logic signed [39:0]       r5_sens;
    logic signed [TEMP_W-1:0] r5_temp;

    assign n5_off  = {{2{r4_off_lin[37]}}, r4_off_lin} - r4_off2;
    assign n5_sens = {{2{r4_sens_lin[37]}}, r4_sens_lin} - r4_sens2;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_d1   <= r4_d1;
            r5_off  <= n5_off;
            r5_sens <= n5_sens;
            r5_temp <= r4_temp;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: pressure reading times sensitivity, as two partial
    // products over the low and high halves of the sensitivity.
    // ------------------------------------------------------------------
    logic        [43:0] n6_pl;
    logic signed [44:0] n6_ph;

    logic        [43:0]       r6_pl;
    logic signed [44:0]       r6_ph;
    logic signed [39:0]       r6_off;
    logic signed [TEMP_W-1:0] r6_temp;

    assign n6_pl = r5_d1 * r5_sens[19:0];
    assign n6_ph = $signed({1'b0, r5_d1}) * $signed(r5_sens[39:20]);

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_pl   <= n6_pl;
            r6_ph   <= n6_ph;
            r6_off  <= r5_off;
            r6_temp <= r5_temp;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: combine the partial products and scale down by 2^21.
    // ------------------------------------------------------------------
    logic signed [65:0] s7_prod;

    logic signed [44:0]       r7_scaled;
    logic signed [39:0]       r7_off;
    logic signed [TEMP_W-1:0] r7_temp;

    assign s7_prod = $signed({r6_ph[44], r6_ph, 20'd0}) + $signed({22'd0, r6_pl});

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r7_scaled <= s7_prod[65:21];
            r7_off    <= r6_off;
            r7_temp   <= r6_temp;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: remove the offset, scale by 2^15 and saturate. These
    // registers drive the result beat.
    // ------------------------------------------------------------------
    logic signed [47:0]        s8_diff;
    logic signed [32:0]        s8_press_full;
    logic signed [PRESS_W-1:0] n8_press;

    logic signed [PRESS_W-1:0] r8_press;
    logic signed [TEMP_W-1:0]  r8_temp;

    assign s8_diff       = {{3{r7_scaled[44]}}, r7_scaled} - {{8{r7_off[39]}}, r7_off};
    assign s8_press_full = s8_diff[47:15];

    always_comb begin
        priority if (s8_press_full > PRESS_OUT_MAX) begin
            n8_press = PRESS_OUT_MAX[PRESS_W-1:0];
        end else if (s8_press_full < PRESS_OUT_MIN) begin
            n8_press = PRESS_OUT_MIN[PRESS_W-1:0];
        end else begin
            n8_press = s8_press_full[PRESS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r8_press <= n8_press;
            r8_temp  <= r7_temp;
        end
    end

    assign o_temperature_centi   = r8_temp;
    assign o_pressure_centi_mbar = r8_press;

endmodule

`default_nettype wire
